// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHK_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wtdh_pkg.sv =====
`timescale 1ns / 1ps

package wtdh_pkg;

	// field widths
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned HASH_W       = 64;
	localparam int unsigned LEN_W        = 6;
	localparam int unsigned TOTAL_W      = 32;
	localparam int unsigned BUCKET_OUT_W = 20;

	// word letter cap and letter counter width
	localparam int unsigned WORD_CAP = 64;
	localparam int unsigned CNT_W    = $clog2(WORD_CAP);

	// bucket count and width of a remainder
	localparam logic [63:0] BUCKETS = 64'd1000003;
	localparam int unsigned BKT_W   = $clog2(BUCKETS + 64'd1);

	localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

	// remainder unit: the hash is cut into digits, each weighted by its
	// power of two modulo the bucket count, then reduced by restoring steps
	localparam int unsigned DIGIT_W         = 16;
	localparam int unsigned NDIG            = HASH_W / DIGIT_W;
	localparam int unsigned PROD_W          = DIGIT_W + BKT_W;
	localparam int unsigned RED_STEPS       = DIGIT_W + 2;
	localparam int unsigned RED_W           = BKT_W + RED_STEPS;
	localparam int unsigned STEPS_PER_STAGE = 2;
	localparam int unsigned RED_STAGES      = RED_STEPS / STEPS_PER_STAGE;
	localparam logic [RED_W-1:0] RED_BKT    = RED_W'(BUCKETS);

	// queue between tokenizer and remainder unit (power of two)
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// character codes
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_VT     = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_EXCL   = 8'h21;
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_PERIOD = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_BIT  = 8'h20;

	// one finished word on its way to the remainder unit
	typedef struct packed {
		logic [HASH_W-1:0]  hash;
		logic [LEN_W-1:0]   len;
		logic [TOTAL_W-1:0] total;
	} word_t;

	// whitespace and punctuation that end a word
	function automatic logic is_delim(input logic [BYTE_W-1:0] b);
		logic d;
		unique case (b)
			CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE,
			CH_COMMA, CH_PERIOD, CH_SEMI, CH_COLON, CH_EXCL, CH_QUEST,
			CH_DQUOTE, CH_SQUOTE, CH_LPAREN, CH_RPAREN,
			CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: d = 1'b1;
			default:                                    d = 1'b0;
		endcase
		return d;
	endfunction

	// weight of hash digit i: 2^(DIGIT_W*i) modulo the bucket count
	function automatic logic [BKT_W-1:0] digit_weight(input int unsigned i);
		return BKT_W'((64'd1 << (DIGIT_W * i)) % BUCKETS);
	endfunction

	// one restoring step: take off the shifted bucket count if it fits
	function automatic logic [RED_W-1:0] red_step(input logic [RED_W-1:0] x,
			input logic [RED_W-1:0] bk);
		return (x >= bk) ? x - bk : x;
	endfunction

endpackage

// ===== rtl/core/wtdh_front.sv =====
`timescale 1ns / 1ps

module wtdh_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wtdh_pkg::BYTE_W-1:0]    byte_in,
	input  logic                           end_of_stream,
	input  logic                           q_full,
	output logic                           push,
	output wtdh_pkg::word_t                push_word
);

	logic [wtdh_pkg::HASH_W-1:0]  hash_q;
	logic [wtdh_pkg::CNT_W-1:0]   cnt_q;
	logic [wtdh_pkg::TOTAL_W-1:0] words_q;

	logic                         take;
	logic                         is_up;
	logic [wtdh_pkg::BYTE_W-1:0]  lc;
	logic                         is_letter;
	logic                         delim;
	logic                         keep;
	logic                         close;
	logic                         emit;
	logic [wtdh_pkg::HASH_W-1:0]  hash_upd;
	logic [wtdh_pkg::CNT_W-1:0]   cnt_upd;
	logic [wtdh_pkg::TOTAL_W-1:0] total_upd;

	// a request is taken whenever the queue has room
	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	// classify the byte and fold a kept letter into the hash
	always_comb begin
		is_up     = (byte_in >= wtdh_pkg::CH_UP_A) && (byte_in <= wtdh_pkg::CH_UP_Z);
		lc        = is_up ? (byte_in | wtdh_pkg::CASE_BIT) : byte_in;
		is_letter = (lc >= wtdh_pkg::CH_LO_A) && (lc <= wtdh_pkg::CH_LO_Z);
		delim     = wtdh_pkg::is_delim(byte_in);
		keep      = !delim && is_letter &&
			(cnt_q < wtdh_pkg::CNT_W'(wtdh_pkg::WORD_CAP - 1));
		hash_upd  = keep ? (hash_q << 5) + hash_q + wtdh_pkg::HASH_W'(lc) : hash_q;
		cnt_upd   = keep ? cnt_q + 1'b1 : cnt_q;
		close     = delim || end_of_stream;
		emit      = close && (cnt_upd >= wtdh_pkg::CNT_W'(2));
		total_upd = (words_q != '1) ? words_q + 1'b1 : words_q;
	end

	// finished word into the queue
	assign push            = take && emit;
	assign push_word.hash  = hash_upd;
	assign push_word.len   = wtdh_pkg::LEN_W'(cnt_upd);
	assign push_word.total = total_upd;

	// word state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= wtdh_pkg::HASH_SEED;
			cnt_q   <= '0;
			words_q <= '0;
		end else if (take) begin
			if (close) begin
				hash_q <= wtdh_pkg::HASH_SEED;
				cnt_q  <= '0;
			end else begin
				hash_q <= hash_upd;
				cnt_q  <= cnt_upd;
			end
			if (emit) begin
				words_q <= total_upd;
			end
		end
	end

endmodule

// ===== rtl/core/wtdh_fifo.sv =====
`timescale 1ns / 1ps

module wtdh_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wtdh_pkg::word_t push_word,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output wtdh_pkg::word_t head_word
);

	wtdh_pkg::word_t                mem_q [wtdh_pkg::QUEUE_DEPTH];
	logic [wtdh_pkg::QPTR_W-1:0]    wr_q;
	logic [wtdh_pkg::QPTR_W-1:0]    rd_q;
	logic [wtdh_pkg::QPTR_W:0]      cnt_q;

	assign full       = (cnt_q == (wtdh_pkg::QPTR_W + 1)'(wtdh_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_word  = mem_q[rd_q];

	// pointers and fill level; pointers wrap with the power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

endmodule

// ===== rtl/core/wtdh_back.sv =====
`timescale 1ns / 1ps

module wtdh_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  wtdh_pkg::word_t                    q_word,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wtdh_pkg::BUCKET_OUT_W-1:0]  bucket_index,
	output logic [wtdh_pkg::HASH_W-1:0]        word_hash,
	output logic [wtdh_pkg::LEN_W-1:0]         word_length,
	output logic [wtdh_pkg::TOTAL_W-1:0]       words_total
);

	localparam int unsigned LAST = wtdh_pkg::RED_STAGES - 1;

	logic                               en;

	// stage 1: weighted digits
	logic                               v_s1;
	wtdh_pkg::word_t                    w_s1;
	logic [wtdh_pkg::DIGIT_W-1:0]       d0_s1;
	logic [wtdh_pkg::PROD_W-1:0]        prod_s1 [1:wtdh_pkg::NDIG-1];

	// stage 2: folded value, below 2^RED_STEPS times the bucket count
	logic                               v_s2;
	wtdh_pkg::word_t                    w_s2;
	logic [wtdh_pkg::RED_W-1:0]         x_s2;
	logic [wtdh_pkg::RED_W-1:0]         fold_sum;

	// stages 3 onwards: restoring reduction, the last one is the output
	logic [wtdh_pkg::RED_STAGES-1:0]    red_v_s3;
	wtdh_pkg::word_t                    red_w_s3 [wtdh_pkg::RED_STAGES];
	logic [wtdh_pkg::RED_W-1:0]         red_x_s3 [wtdh_pkg::RED_STAGES];
	logic [wtdh_pkg::RED_W-1:0]         red_nx   [wtdh_pkg::RED_STAGES];

	// whole pipe moves unless the output holds a result nobody takes
	assign en    = !out_valid || out_ready;
	assign q_pop = en && q_valid;

	// sum of weighted digits
	always_comb begin
		fold_sum = wtdh_pkg::RED_W'(d0_s1);
		for (int i = 1; i < wtdh_pkg::NDIG; i++) begin
			fold_sum = fold_sum + wtdh_pkg::RED_W'(prod_s1[i]);
		end
	end

	// restoring steps of each reduction stage, highest multiple first
	always_comb begin
		logic [wtdh_pkg::RED_W-1:0] xin;
		for (int g = 0; g < wtdh_pkg::RED_STAGES; g++) begin
			xin = (g == 0) ? x_s2 : red_x_s3[(g == 0) ? 0 : g - 1];
			for (int j = 0; j < wtdh_pkg::STEPS_PER_STAGE; j++) begin
				xin = wtdh_pkg::red_step(xin, wtdh_pkg::RED_BKT <<
					(wtdh_pkg::RED_STEPS - 1 - (g * wtdh_pkg::STEPS_PER_STAGE + j)));
			end
			red_nx[g] = xin;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			red_v_s3 <= '0;
		end else if (en) begin
			v_s1     <= q_valid;
			v_s2     <= v_s1;
			red_v_s3 <= {red_v_s3[wtdh_pkg::RED_STAGES-2:0], v_s2};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1  <= q_word;
			d0_s1 <= q_word.hash[wtdh_pkg::DIGIT_W-1:0];
			for (int i = 1; i < wtdh_pkg::NDIG; i++) begin
				prod_s1[i] <= wtdh_pkg::PROD_W'(q_word.hash[i*wtdh_pkg::DIGIT_W +: wtdh_pkg::DIGIT_W])
					* wtdh_pkg::PROD_W'(wtdh_pkg::digit_weight(i));
			end
			w_s2 <= w_s1;
			x_s2 <= fold_sum;
			for (int g = 0; g < wtdh_pkg::RED_STAGES; g++) begin
				red_x_s3[g] <= red_nx[g];
				red_w_s3[g] <= (g == 0) ? w_s2 : red_w_s3[(g == 0) ? 0 : g - 1];
			end
		end
	end

	// result ports
	assign out_valid    = red_v_s3[LAST];
	assign bucket_index = red_x_s3[LAST][wtdh_pkg::BUCKET_OUT_W-1:0];
	assign word_hash    = red_w_s3[LAST].hash;
	assign word_length  = red_w_s3[LAST].len;
	assign words_total  = red_w_s3[LAST].total;

endmodule

// ===== rtl/core/word_tokenizer_djb2_hasher.sv =====
// Word tokenizer with a 64-bit djb2 hash per word.
// Input channel (in_valid/in_ready): one text byte per request with an
// end_of_stream flag. Letters are lowercased and hashed, delimiters close the
// word, other bytes are dropped. Up to 63 letters of a word are kept.
// Output channel (out_valid/out_ready): one request per word of two or more
// letters, carrying hash, bucket (hash modulo 1000003), length and the
// saturating word total.
// Throughput: one byte per cycle while the queue has room; a finished word enters a
// four-entry queue in the cycle its closing byte is taken.
// Path: after its closing byte is accepted, a word passes the queue, a
// digit-weighting multiply stage, a fold stage and nine remainder stages
// of two restoring steps each.
// Stall: while a valid result waits on out_ready it holds and the whole back
// pipe freezes; bytes are still taken until the queue fills, then in_ready drops.
// Reset: arst_n clears the open word, the word total and all valid bits; the
// block comes out of reset ready to take bytes.
`timescale 1ns / 1ps

module word_tokenizer_djb2_hasher (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [wtdh_pkg::BYTE_W-1:0]        byte_in,
	input  logic                               end_of_stream,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wtdh_pkg::BUCKET_OUT_W-1:0]  bucket_index,
	output logic [wtdh_pkg::HASH_W-1:0]        word_hash,
	output logic [wtdh_pkg::LEN_W-1:0]         word_length,
	output logic [wtdh_pkg::TOTAL_W-1:0]       words_total
);

	logic            push;
	wtdh_pkg::word_t push_word;
	logic            q_full;
	logic            q_pop;
	logic            q_valid;
	wtdh_pkg::word_t q_word;

	// tokenizer and hash
	wtdh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_in       (byte_in),
		.end_of_stream (end_of_stream),
		.q_full        (q_full),
		.push          (push),
		.push_word     (push_word)
	);

	// word queue
	wtdh_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_word  (q_word)
	);

	// bucket remainder and output
	wtdh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_word       (q_word),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index),
		.word_hash    (word_hash),
		.word_length  (word_length),
		.words_total  (words_total)
	);

endmodule

// ===== rtl/core/wtdh_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wtdh_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [wtdh_pkg::BUCKET_OUT_W-1:0]  bucket_index,
	input  logic [wtdh_pkg::HASH_W-1:0]        word_hash,
	input  logic [wtdh_pkg::LEN_W-1:0]         word_length,
	input  logic [wtdh_pkg::TOTAL_W-1:0]       words_total
);

	logic                         seen_q;
	logic [wtdh_pkg::TOTAL_W-1:0] last_total_q;

	// total of the last result handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_total_q <= '0;
		end else if (out_valid && out_ready) begin
			seen_q       <= 1'b1;
			last_total_q <= words_total;
		end
	end

	// a stalled result holds
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(word_hash) && $stable(words_total) && $stable(bucket_index), "stalled result changed")

	// only words of two or more letters come out
	`CHK_HOLDS(a_len_min, clk, arst_n, out_valid |-> (word_length >= 6'd2), "short word emitted")

	// bucket stays below the bucket count
	`CHK_HOLDS(a_bkt_range, clk, arst_n, out_valid |-> (64'(bucket_index) < wtdh_pkg::BUCKETS), "bucket out of range")

	// word total steps by one per result until it saturates
	`CHK_HOLDS(a_total_seq, clk, arst_n, (out_valid && seen_q) |-> ((words_total == last_total_q + 32'd1) || ((last_total_q == '1) && (words_total == '1))), "word total out of sequence")

	// first word after reset carries a total of one
	`CHK_HOLDS(a_first_total, clk, arst_n, (out_valid && !seen_q) |-> (words_total == 32'd1), "first word total wrong")

endmodule

bind word_tokenizer_djb2_hasher wtdh_checker u_wtdh_checker (.*);

// ===== dv/word_tokenizer_djb2_hasher_tb.sv =====
`timescale 1ns / 1ps

module word_tokenizer_djb2_hasher_tb;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned TAIL_CYCLES  = 24;
	localparam int unsigned NUM_DELIMS   = 20;

	// every byte that ends a word, packed so it can be indexed and searched
	localparam logic [NUM_DELIMS*wtdh_pkg::BYTE_W-1:0] DELIM_LIST = {
		wtdh_pkg::CH_TAB, wtdh_pkg::CH_LF, wtdh_pkg::CH_VT, wtdh_pkg::CH_FF,
		wtdh_pkg::CH_CR, wtdh_pkg::CH_SPACE, wtdh_pkg::CH_COMMA, wtdh_pkg::CH_PERIOD,
		wtdh_pkg::CH_SEMI, wtdh_pkg::CH_COLON, wtdh_pkg::CH_EXCL, wtdh_pkg::CH_QUEST,
		wtdh_pkg::CH_DQUOTE, wtdh_pkg::CH_SQUOTE, wtdh_pkg::CH_LPAREN,
		wtdh_pkg::CH_RPAREN, wtdh_pkg::CH_LBRACK, wtdh_pkg::CH_RBRACK,
		wtdh_pkg::CH_LBRACE, wtdh_pkg::CH_RBRACE
	};

	typedef struct {
		logic [wtdh_pkg::BUCKET_OUT_W-1:0] bucket;
		logic [wtdh_pkg::HASH_W-1:0]       hash;
		logic [wtdh_pkg::LEN_W-1:0]        len;
		logic [wtdh_pkg::TOTAL_W-1:0]      total;
	} word_result_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [wtdh_pkg::BYTE_W-1:0]       byte_in;
	logic                              end_of_stream;
	logic                              out_valid;
	logic                              out_ready;
	logic [wtdh_pkg::BUCKET_OUT_W-1:0] bucket_index;
	logic [wtdh_pkg::HASH_W-1:0]       word_hash;
	logic [wtdh_pkg::LEN_W-1:0]        word_length;
	logic [wtdh_pkg::TOTAL_W-1:0]      words_total;

	// running word state of the predictor
	logic [wtdh_pkg::HASH_W-1:0]  open_hash;
	int unsigned                  open_letters;
	logic [wtdh_pkg::TOTAL_W-1:0] emitted_words;

	word_result_t expected_words[$];

	int unsigned bytes_taken;
	int unsigned bytes_driven;
	int unsigned words_checked;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	word_tokenizer_djb2_hasher uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_in       (byte_in),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bucket_index  (bucket_index),
		.word_hash     (word_hash),
		.word_length   (word_length),
		.words_total   (words_total)
	);

	// clock
	always #2 clk = ~clk;

	function automatic bit is_delimiter(input logic [wtdh_pkg::BYTE_W-1:0] b);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_DELIMS; i++)
			if (DELIM_LIST[i*wtdh_pkg::BYTE_W +: wtdh_pkg::BYTE_W] == b)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic bit is_letter(input logic [wtdh_pkg::BYTE_W-1:0] b);
		return (b >= wtdh_pkg::CH_UP_A && b <= wtdh_pkg::CH_UP_Z) ||
			(b >= wtdh_pkg::CH_LO_A && b <= wtdh_pkg::CH_LO_Z);
	endfunction

	// end the open word, queueing a result if it has two letters or more
	function automatic void close_word();
		word_result_t w;
		if (open_letters >= 2) begin
			if (emitted_words != '1)
				emitted_words = emitted_words + 1'b1;
			w.bucket = wtdh_pkg::BUCKET_OUT_W'(open_hash % wtdh_pkg::BUCKETS);
			w.hash   = open_hash;
			w.len    = wtdh_pkg::LEN_W'(open_letters);
			w.total  = emitted_words;
			expected_words.push_back(w);
		end
		open_hash    = wtdh_pkg::HASH_SEED;
		open_letters = 0;
	endfunction

	// fold one accepted byte into the word state
	function automatic void predict_byte(input logic [wtdh_pkg::BYTE_W-1:0] b,
			input logic eos);
		logic [wtdh_pkg::BYTE_W-1:0] c;
		if (is_delimiter(b)) begin
			close_word();
		end else if (is_letter(b) && open_letters < wtdh_pkg::WORD_CAP - 1) begin
			c            = b | wtdh_pkg::CASE_BIT;
			open_hash    = open_hash * 64'd33 + wtdh_pkg::HASH_W'(c);
			open_letters = open_letters + 1;
		end
		// a word already closed by the delimiter has no letters left
		if (eos)
			close_word();
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// predict on accepted requests, check results against the oldest word
	always @(posedge clk) begin
		word_result_t w;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_byte(byte_in, end_of_stream);
				bytes_taken++;
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual hash %0h len %0d",
						$time, word_hash, word_length);
					error_count++;
				end else begin
					w = expected_words.pop_front();
					check_field("bucket_index", 64'(w.bucket), 64'(bucket_index));
					check_field("word_hash", w.hash, word_hash);
					check_field("word_length", 64'(w.len), 64'(word_length));
					check_field("words_total", 64'(w.total), 64'(words_total));
					words_checked++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
			$display("word_tokenizer_djb2_hasher regression: fail");
			$finish;
		end
	end

	// drive one request at the falling edge and hold it until taken
	task automatic send_byte(input logic [wtdh_pkg::BYTE_W-1:0] b, input logic eos);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		byte_in       <= b;
		end_of_stream <= eos;
		bytes_driven++;
		do
			@(negedge clk);
		while (bytes_taken != bytes_driven);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// sender holds off until every word in flight has come out
	task automatic wait_for_words();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_words.size() != 0);
	endtask

	function automatic logic [wtdh_pkg::BYTE_W-1:0] random_letter();
		return wtdh_pkg::BYTE_W'($urandom_range(0, 25)) +
			($urandom_range(0, 1) ? wtdh_pkg::CH_UP_A : wtdh_pkg::CH_LO_A);
	endfunction

	function automatic logic [wtdh_pkg::BYTE_W-1:0] random_delimiter();
		return DELIM_LIST[$urandom_range(0, NUM_DELIMS-1)*wtdh_pkg::BYTE_W +: wtdh_pkg::BYTE_W];
	endfunction

	// any byte that is neither a letter nor a delimiter
	function automatic logic [wtdh_pkg::BYTE_W-1:0] random_noise();
		logic [wtdh_pkg::BYTE_W-1:0] b;
		b = wtdh_pkg::BYTE_W'($urandom_range(0, 255));
		while (is_letter(b) || is_delimiter(b))
			b = wtdh_pkg::BYTE_W'($urandom_range(0, 255));
		return b;
	endfunction

	// letter range edges in both cases
	task automatic test_case_folding();
		send_text("AZ az,Zebra.aZ ");
	endtask

	// one-letter words and delimiters with no open word
	task automatic test_short_and_empty_words();
		send_text("q;  .x)");
	endtask

	// dropped bytes inside a word must not split it
	task automatic test_dropped_bytes();
		send_byte("a", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte("B", 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte("7", 1'b0);
		send_byte("c", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte("-", 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte("d", 1'b0);
		send_byte(" ", 1'b0);
	endtask

	// letters past the cap change neither hash nor length
	task automatic test_letter_cap();
		for (int i = 0; i < wtdh_pkg::WORD_CAP + 6; i++)
			send_byte((i % 2) ? "z" : "A", 1'b0);
		send_byte("}", 1'b0);
	endtask

	// end of stream on a letter, a delimiter, a dropped byte and an empty word
	task automatic test_end_of_stream();
		send_text("o");
		send_byte("k", 1'b1);
		send_text("hi");
		send_byte("!", 1'b1);
		send_byte("x", 1'b1);
		send_text("go");
		send_byte(8'hC3, 1'b1);
		send_byte(",", 1'b1);
	endtask

	// mostly words of random letters, some delimiter runs and raw noise
	task automatic test_random_text(input int unsigned n_items, input bit pause_midway);
		int unsigned counted;
		int unsigned len;
		int unsigned pick;
		logic [wtdh_pkg::BYTE_W-1:0] b;
		logic eos;
		counted = 0;
		while (counted < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 75) : $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 19) == 0)
						send_byte(random_noise(), 1'b0);
					send_byte(random_letter(), (i == len - 1) && ($urandom_range(0, 9) == 0));
				end
				send_byte(random_delimiter(), $urandom_range(0, 9) == 0);
				counted += len + 1;
			end else if (pick < 85) begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					send_byte(random_delimiter(), $urandom_range(0, 7) == 0);
				counted += len;
			end else begin
				b   = wtdh_pkg::BYTE_W'($urandom_range(0, 255));
				eos = ($urandom_range(0, 7) == 0);
				send_byte(b, eos);
				if (eos || is_letter(b) || is_delimiter(b))
					counted++;
			end
			if (pause_midway && counted >= n_items / 2) begin
				pause_midway = 1'b0;
				wait_for_words();
			end
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		byte_in       = '0;
		end_of_stream = 1'b0;
		out_ready     = 1'b0;
		bytes_taken   = 0;
		bytes_driven  = 0;
		words_checked = 0;
		error_count   = 0;
		cycle_count   = 0;
		open_hash     = wtdh_pkg::HASH_SEED;
		open_letters  = 0;
		emitted_words = '0;
		send_idle_pct = 16;
		recv_idle_pct = 78;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_case_folding();
		test_short_and_empty_words();
		test_dropped_bytes();
		test_letter_cap();
		test_end_of_stream();
		test_random_text(170, 1'b1);

		send_idle_pct = 78;
		recv_idle_pct = 16;
		test_random_text(170, 1'b0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_text(170, 1'b1);

		// drain and let the pipe settle
		wait_for_words();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("bytes taken: %0d, words checked: %0d, over three idle mixes", bytes_taken,
			words_checked);
		$display("covered case folding, short and empty words, dropped bytes, cap, end of stream");
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("word_tokenizer_djb2_hasher regression: pass");
		end else begin
			$display("%0d mismatches, %0d words never seen", error_count, expected_words.size());
			$display("word_tokenizer_djb2_hasher regression: fail");
		end
		$finish;
	end

endmodule
